FILE: rtl/core/civ_pkg.sv
// ============================================================================
// civ_pkg
// Shared types, constants and month tables for the civil date to epoch
// seconds converter.
// ============================================================================
package civ_pkg;

    // input beat: broken-down civil date and time
    typedef struct packed {
        logic signed [13:0] year_since_1900;
        logic [3:0]         month_index;
        logic [4:0]         day_of_month;
        logic [4:0]         hour_of_day;
        logic [5:0]         minute_of_hour;
        logic [5:0]         second_of_minute;
    } civ_stamp_t;

    // output beat
    typedef struct packed {
        logic signed [38:0] epoch_seconds;
        logic [8:0]         day_of_year;
        logic [2:0]         weekday;
        logic               date_valid;
    } civ_result_t;

    // calendar stage to day count stage
    typedef struct packed {
        logic        date_ok;
        logic [14:0] prev_year;   // biased full year minus one, always positive
        logic [8:0]  prev_cent;   // floor(prev_year / 100)
        logic [8:0]  doy;
        logic [16:0] tod;         // seconds within the day, unchecked fields
    } civ_cal_t;

    // day count stage to seconds stage
    typedef struct packed {
        logic               date_ok;
        logic signed [23:0] days;  // days since 1970-01-01
        logic [8:0]         doy;
        logic [16:0]        tod;
    } civ_day_t;

    // month codes
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_MAR = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    // year bias: 1900 plus 6400, a multiple of 400, keeps the year positive
    localparam logic [15:0] YEAR_BIAS = 16'd8300;

    // floor(x / 100) for x below 2^15 as (x * DIV100_MUL) >> 19
    localparam logic [27:0] DIV100_MUL = 28'd5243;

    // day count constant: bias terms of the leap sums plus days from 0001 to 1970
    localparam int DAY_BIAS = -3056714;

    // keeps days + 4 positive for the weekday fold, a multiple of 7 plus 4
    localparam int WEEK_BIAS = 3670020;

    localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;

    // days before the first of each month in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // month length in a common year
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] n;
        case (month)
            4'd1:                         n = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:      n = 5'd30;
            4'd0, 4'd2, 4'd4, 4'd6,
            4'd7, 4'd9, 4'd11:            n = 5'd31;
            default:                      n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/civil_date_to_epoch_seconds.sv
// ============================================================================
// civil_date_to_epoch_seconds
// Converts a broken-down Gregorian date and time to signed seconds since
// 1970-01-01 UTC less a zone offset, with day of year and weekday.
// ============================================================================
// an accepted start beat passes the calendar, day count and seconds stage registers in turn before done rises
// throughput: one beat per cycle, busy stays low, five pipeline registers
// the receiver cannot stall; every result shows for one cycle under done
// reset clears the stage valid bits and sets the zone offset to zero
module civil_date_to_epoch_seconds
    import civ_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  civ_stamp_t         stamp,
    input  logic               offset_wr,
    input  logic signed [16:0] offset_data,
    output logic               done,
    output civ_result_t        result
);

    logic signed [16:0] offset_reg;

    logic     cal_valid;
    civ_cal_t cal;
    logic     day_valid;
    civ_day_t day;

    // zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (offset_wr)
        begin
            offset_reg <= offset_data;
        end
    end

    // pipeline takes a beat every cycle
    assign busy = 1'b0;

    civ_calendar u_calendar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .stamp     (stamp),
        .out_valid (cal_valid),
        .cal       (cal)
    );

    civ_day_count u_day_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cal_valid),
        .cal       (cal),
        .out_valid (day_valid),
        .day       (day)
    );

    civ_seconds u_seconds (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (day_valid),
        .day      (day),
        .offset   (offset_reg),
        .done     (done),
        .result   (result)
    );

    // every accepted beat comes out as a done beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("accepted beat produced no result");

    // no result without an earlier accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without an accepted beat");

    // a bad date reports all fields zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.date_valid) |->
            (result.epoch_seconds == '0) && (result.day_of_year == '0)
            && (result.weekday == '0))
        else $error("invalid date with nonzero fields");

    // a good date gives a weekday and day of year in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.date_valid) |->
            (result.weekday != 3'd7) && (result.day_of_year <= 9'd365))
        else $error("weekday or day of year out of range");

endmodule

FILE: rtl/core/civ_calendar.sv
// ============================================================================
// civ_calendar
// Two stages: year bias, century quotient, field checks and time of day, then
// leap rule, month length check and day of year.
// ============================================================================
module civ_calendar
    import civ_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  civ_stamp_t stamp,
    output logic       out_valid,
    output civ_cal_t   cal
);

    logic        s1_valid_reg;
    logic [14:0] yadj_reg;
    logic [8:0]  cent_reg;
    logic        fields_ok_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [16:0] tod_reg;

    logic        s2_valid_reg;
    civ_cal_t    cal_reg;

    logic [15:0] yadj_full;
    logic [27:0] cent_prod;
    logic [16:0] tod_next;

    logic [14:0] rem_full;
    logic [6:0]  rem100;
    logic        leap;
    logic [4:0]  len;
    civ_cal_t    cal_next;

    // stage 1: biased year, its century quotient, field checks and time of day
    always_comb
    begin
        yadj_full = 16'(stamp.year_since_1900) + YEAR_BIAS;
        cent_prod = 28'(yadj_full[14:0]) * DIV100_MUL;
        tod_next  = 17'(stamp.hour_of_day) * 17'd3600
                  + 17'(stamp.minute_of_hour) * 17'd60
                  + 17'(stamp.second_of_minute);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        yadj_reg      <= yadj_full[14:0];
        cent_reg      <= cent_prod[27:19];
        fields_ok_reg <= (stamp.month_index <= MONTH_DEC) && (stamp.day_of_month != 5'd0);
        month_reg     <= stamp.month_index;
        day_reg       <= stamp.day_of_month;
        tod_reg       <= tod_next;
    end

    // stage 2: leap rule, month length check, day of year
    always_comb
    begin
        rem_full = yadj_reg - 15'(cent_reg) * 15'd100;
        rem100   = rem_full[6:0];
        leap     = (yadj_reg[1:0] == 2'd0) && ((rem100 != 7'd0) || (cent_reg[1:0] == 2'd0));
        len      = month_len(month_reg) + 5'((month_reg == MONTH_FEB) && leap);

        cal_next.date_ok   = fields_ok_reg && (day_reg <= len);
        cal_next.prev_year = yadj_reg - 15'd1;
        cal_next.prev_cent = (rem100 == 7'd0) ? cent_reg - 9'd1 : cent_reg;
        cal_next.doy       = cum_days(month_reg) + 9'(day_reg) - 9'd1
                           + 9'((month_reg >= MONTH_MAR) && leap);
        cal_next.tod       = tod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cal_reg <= cal_next;
    end

    assign out_valid = s2_valid_reg;
    assign cal       = cal_reg;

endmodule

FILE: rtl/core/civ_day_count.sv
// ============================================================================
// civ_day_count
// One stage: days since 1970-01-01 from the year terms and the day of year.
// ============================================================================
module civ_day_count
    import civ_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  civ_cal_t cal,
    output logic     out_valid,
    output civ_day_t day
);

    logic        valid_reg;
    civ_day_t    day_reg;

    logic [22:0] mul365;
    logic [24:0] sum;
    civ_day_t    day_next;

    // 365*p + p/4 - p/100 + p/400 + doy, bias folded into one constant
    always_comb
    begin
        mul365 = 23'(cal.prev_year) * 23'd365;
        sum    = 25'(mul365)
               + 25'(cal.prev_year[14:2])
               + 25'(cal.prev_cent[8:2])
               + 25'(cal.doy)
               - 25'(cal.prev_cent)
               + 25'(DAY_BIAS);

        day_next.date_ok = cal.date_ok;
        day_next.days    = signed'(sum[23:0]);
        day_next.doy     = cal.doy;
        day_next.tod     = cal.tod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg <= day_next;
    end

    assign out_valid = valid_reg;
    assign day       = day_reg;

endmodule

FILE: rtl/core/civ_seconds.sv
// ============================================================================
// civ_seconds
// Two stages: day to seconds product and weekday digit fold, then time of
// day, zone offset, weekday finish and the output register.
// ============================================================================
module civ_seconds
    import civ_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  civ_day_t           day,
    input  logic signed [16:0] offset,
    output logic               done,
    output civ_result_t        result
);

    logic               s4_valid_reg;
    logic               ok_reg;
    logic signed [39:0] prod_reg;
    logic [5:0]         fold_reg;
    logic [8:0]         doy_reg;
    logic [16:0]        tod_reg;

    logic               done_reg;
    civ_result_t        result_reg;

    logic signed [41:0] prod;
    logic [23:0]        wk;
    logic [5:0]         fold;

    logic [39:0]        secs;
    logic [3:0]         fold2;
    logic [2:0]         fold3;
    logic [2:0]         wd;
    civ_result_t        result_next;

    // stage 4: multiply, octal digit sum of the shifted day count (8 = 1 mod 7)
    always_comb
    begin
        prod = day.days * SEC_PER_DAY;
        wk   = 24'(day.days) + 24'(WEEK_BIAS);
        fold = 6'd0;
        for (int i = 0; i < 8; i++)
        begin
            fold = fold + 6'(wk[3*i +: 3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= day.date_ok;
        prod_reg <= prod[39:0];
        fold_reg <= fold;
        doy_reg  <= day.doy;
        tod_reg  <= day.tod;
    end

    // stage 5: seconds total, weekday finish, zeroed fields on a bad date
    always_comb
    begin
        secs  = prod_reg + 40'(tod_reg) - 40'(offset);
        fold2 = 4'(fold_reg[5:3]) + 4'(fold_reg[2:0]);
        fold3 = 3'(fold2[3]) + fold2[2:0];
        wd    = (fold3 == 3'd7) ? 3'd0 : fold3;

        result_next.date_valid = ok_reg;
        if (ok_reg)
        begin
            result_next.epoch_seconds = signed'(secs[38:0]);
            result_next.day_of_year   = doy_reg;
            result_next.weekday       = wd;
        end
        else
        begin
            result_next.epoch_seconds = '0;
            result_next.day_of_year   = '0;
            result_next.weekday       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: tb/epoch_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// epoch_result_checker
// Watches the stamp, offset and result channels of the date converter. It
// predicts each result from the accepted stamp beat and the zone offset held
// at that time, then compares every done beat against the oldest prediction.
// ============================================================================
module epoch_result_checker
    import civ_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  civ_stamp_t         stamp,
    input  logic               offset_wr,
    input  logic signed [16:0] offset_data,
    input  logic               done,
    input  civ_result_t        result,
    output int                 mismatch_count,
    output int                 results_owed
);

    // predictions waiting for their done beat, oldest first
    civ_result_t pending_results[$];
    // zone offset as the block should hold it
    logic signed [16:0] zone_offset;
    int errors;

    // days in a common year before the first of a month, index 12 is the year
    function automatic int days_before_month(input int m);
        case (m)
            0:       return 0;
            1:       return 31;
            2:       return 59;
            3:       return 90;
            4:       return 120;
            5:       return 151;
            6:       return 181;
            7:       return 212;
            8:       return 243;
            9:       return 273;
            10:      return 304;
            11:      return 334;
            default: return 365;
        endcase
    endfunction

    // division rounding toward minus infinity
    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // expected result for one stamp beat under a given zone offset
    function automatic civ_result_t to_epoch(input civ_stamp_t s,
                                             input logic signed [16:0] ofs);
        civ_result_t r;
        longint full_year;
        longint prior;
        longint days;
        longint secs;
        longint wkday;
        int m;
        int leap;
        int span;
        int doy;
        r = '0;
        full_year = 1900 + longint'($signed(s.year_since_1900));
        m = int'(s.month_index);
        if (s.month_index > MONTH_DEC || s.day_of_month == 5'd0)
            return r;
        leap = (((full_year % 4) == 0 && (full_year % 100) != 0) ||
                (full_year % 400) == 0) ? 1 : 0;
        span = days_before_month(m + 1) - days_before_month(m);
        if (s.month_index == MONTH_FEB)
            span = span + leap;
        if (int'(s.day_of_month) > span)
            return r;
        // leap day shifts every month from march on
        doy = days_before_month(m) + int'(s.day_of_month) - 1;
        if (s.month_index >= MONTH_MAR)
            doy = doy + leap;
        prior = full_year - 1;
        days = prior * 365 + floor_quot(prior, 4) - floor_quot(prior, 100)
             + floor_quot(prior, 400) - 719162 + doy;
        secs = days * 86400 + longint'(s.hour_of_day) * 3600
             + longint'(s.minute_of_hour) * 60 + longint'(s.second_of_minute)
             - longint'(ofs);
        // 1970-01-01 was a thursday
        wkday = (days + 4) - floor_quot(days + 4, 7) * 7;
        r.epoch_seconds = secs[38:0];
        r.day_of_year   = doy[8:0];
        r.weekday       = wkday[2:0];
        r.date_valid    = 1'b1;
        return r;
    endfunction

    // track the channels, retire results, then queue the new prediction
    always @(posedge clk) begin
        civ_result_t want;
        if (!rst_n) begin
            zone_offset = '0;
            errors = 0;
            pending_results.delete();
        end else begin
            if (done) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %0d doy %0d wd %0d v %0b",
                             $time, $signed(result.epoch_seconds), result.day_of_year,
                             result.weekday, result.date_valid);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (result !== want) begin
                        $display("%0t: expected %0d doy %0d wd %0d v %0b, got %0d doy %0d wd %0d v %0b",
                                 $time, $signed(want.epoch_seconds), want.day_of_year,
                                 want.weekday, want.date_valid,
                                 $signed(result.epoch_seconds), result.day_of_year,
                                 result.weekday, result.date_valid);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(to_epoch(stamp, zone_offset));
            if (offset_wr)
                zone_offset = offset_data;
        end
        mismatch_count <= errors;
        results_owed <= pending_results.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives stamp beats into the civil date converter: a directed set of calendar
// corners, then random dates in phases with different zone offsets and idle
// rates. The checker beside the block predicts and compares each result.
// ============================================================================
module testbench;
    import civ_pkg::*;

    localparam logic [3:0] MONTH_JAN  = 4'd0;
    localparam logic [3:0] MONTH_APR  = 4'd3;
    localparam logic [3:0] MONTH_NONE = 4'd12;
    localparam logic [3:0] MONTH_RAW  = 4'd15;

    localparam int BEATS_PER_PHASE = 400;
    localparam int MAX_GAP         = 60;
    localparam int DRAIN_CYCLES    = 12;
    localparam int QUIET_LIMIT     = 2000;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    civ_stamp_t         stamp = '0;
    logic               offset_wr = 1'b0;
    logic signed [16:0] offset_data = '0;
    logic               done;
    civ_result_t        result;
    int                 mismatch_count;
    int                 results_owed;
    int                 quiet_cycles = 0;

    civil_date_to_epoch_seconds dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .stamp       (stamp),
        .offset_wr   (offset_wr),
        .offset_data (offset_data),
        .done        (done),
        .result      (result)
    );

    epoch_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .stamp          (stamp),
        .offset_wr      (offset_wr),
        .offset_data    (offset_data),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || done || offset_wr)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    function automatic civ_stamp_t make_stamp(input int yr, input logic [3:0] mon,
                                              input int d, input int h,
                                              input int mi, input int sc);
        civ_stamp_t s;
        s.year_since_1900  = yr[13:0];
        s.month_index      = mon;
        s.day_of_month     = d[4:0];
        s.hour_of_day      = h[4:0];
        s.minute_of_hour   = mi[5:0];
        s.second_of_minute = sc[5:0];
        return s;
    endfunction

    // mostly legal dates with random content, some raw out-of-range fields
    function automatic civ_stamp_t random_stamp();
        civ_stamp_t s;
        int yr;
        int pick;
        if ($urandom_range(99) < 85)
            yr = int'($urandom_range(9998)) - 1899;
        else
            yr = int'($urandom_range(16383));
        s.year_since_1900 = yr[13:0];
        if ($urandom_range(99) < 92)
            s.month_index = 4'($urandom_range(11));
        else
            s.month_index = 4'($urandom_range(15, 12));
        pick = $urandom_range(99);
        if (pick < 70)
            s.day_of_month = 5'($urandom_range(28, 1));
        else if (pick < 95)
            s.day_of_month = 5'($urandom_range(31, 29));
        else
            s.day_of_month = 5'($urandom_range(31));
        s.hour_of_day = ($urandom_range(99) < 90) ? 5'($urandom_range(23))
                                                  : 5'($urandom_range(31));
        s.minute_of_hour = ($urandom_range(99) < 90) ? 6'($urandom_range(59))
                                                     : 6'($urandom_range(63));
        s.second_of_minute = ($urandom_range(99) < 90) ? 6'($urandom_range(60))
                                                       : 6'($urandom_range(63));
        return s;
    endfunction

    // one stamp beat, then a random idle gap; start stays high with no gap
    task automatic send_beat(input civ_stamp_t s, input int idle_pct);
        int gap;
        gap = 0;
        start <= 1'b1;
        stamp <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every expected result come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic write_offset(input logic signed [16:0] v);
        drain();
        offset_wr <= 1'b1;
        offset_data <= v;
        @(posedge clk);
        offset_wr <= 1'b0;
    endtask

    initial
    begin
        logic signed [16:0] phase_offset;
        int idle_pct;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed calendar corners at the reset offset
        send_beat(make_stamp(70, MONTH_JAN, 1, 0, 0, 0), 0);
        send_beat(make_stamp(-1899, MONTH_JAN, 1, 0, 0, 0), 0);
        send_beat(make_stamp(8099, MONTH_DEC, 31, 23, 59, 60), 0);
        send_beat(make_stamp(-8192, MONTH_JAN, 1, 0, 0, 0), 0);
        send_beat(make_stamp(8191, MONTH_DEC, 31, 31, 63, 63), 0);
        // leap day in a 400 year, two plain centuries, a 4 year and a common year
        send_beat(make_stamp(100, MONTH_FEB, 29, 12, 0, 0), 30);
        send_beat(make_stamp(0, MONTH_FEB, 29, 12, 0, 0), 30);
        send_beat(make_stamp(200, MONTH_FEB, 29, 12, 0, 0), 30);
        send_beat(make_stamp(124, MONTH_FEB, 29, 12, 0, 0), 30);
        send_beat(make_stamp(123, MONTH_FEB, 29, 12, 0, 0), 30);
        send_beat(make_stamp(100, MONTH_MAR, 1, 0, 0, 0), 0);
        send_beat(make_stamp(100, MONTH_DEC, 31, 0, 0, 0), 0);
        send_beat(make_stamp(99, MONTH_DEC, 31, 0, 0, 0), 0);
        // year zero and a negative year
        send_beat(make_stamp(-1900, MONTH_FEB, 29, 0, 0, 0), 0);
        send_beat(make_stamp(-1901, MONTH_JAN, 1, 0, 0, 0), 0);
        // bad month, day zero, day past month end
        send_beat(make_stamp(70, MONTH_JAN, 0, 0, 0, 0), 0);
        send_beat(make_stamp(70, MONTH_NONE, 1, 0, 0, 0), 0);
        send_beat(make_stamp(70, MONTH_RAW, 31, 0, 0, 0), 0);
        send_beat(make_stamp(70, MONTH_APR, 31, 0, 0, 0), 0);
        send_beat(make_stamp(70, MONTH_APR, 30, 0, 0, 0), 0);
        send_beat(make_stamp(70, MONTH_JAN, 31, 23, 59, 59), 0);
        send_beat(make_stamp(69, MONTH_DEC, 31, 23, 59, 59), 0);
        send_beat(make_stamp(138, MONTH_JAN, 19, 3, 14, 8), 0);

        // random phases, each with its own zone offset and idle rate
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin phase_offset = -17'sd50400; idle_pct = 0;  end
                1: begin phase_offset = 17'sd50400;  idle_pct = 80; end
                2: begin phase_offset = -17'sd65536; idle_pct = 0;  end
                3: begin phase_offset = 17'sd65535;  idle_pct = 36; end
                default: begin
                    phase_offset = 17'($urandom_range(131071));
                    idle_pct = 80;
                end
            endcase
            write_offset(phase_offset);
            for (int i = 0; i < BEATS_PER_PHASE; i++)
                send_beat(random_stamp(), idle_pct);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
